>>> design/sfp_pkg.sv
// Shared types and constants for the sync frame parser with sum check.
`timescale 1ns / 1ps

package sfp_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;

  // Configuration address: register i sits at byte address 4*i
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_CODE_PING     = 3'd0,
    REG_CODE_POSITION = 3'd1,
    REG_CODE_TORQUE   = 3'd2,
    REG_CODE_UMBRELLA = 3'd3,
    REG_PAYLOAD_LEN   = 3'd4,
    REG_BUF_CAPACITY  = 3'd5
  } reg_idx_t;

  localparam logic [7:0] RST_CODE_PING     = 8'd0;
  localparam logic [7:0] RST_CODE_POSITION = 8'd1;
  localparam logic [7:0] RST_CODE_TORQUE   = 8'd2;
  localparam logic [7:0] RST_CODE_UMBRELLA = 8'd3;
  localparam logic [7:0] RST_PAYLOAD_LEN   = 8'd54;
  localparam logic [7:0] RST_BUF_CAPACITY  = 8'd54;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_BYTE     = 3'd1,
    EV_GOOD     = 3'd2,
    EV_BADSUM   = 3'd3,
    EV_UNKNOWN  = 3'd4,
    EV_OVERFLOW = 3'd5
  } event_t;

  typedef enum logic [4:0] {
    PH_HUNT1   = 5'b00001,
    PH_HUNT2   = 5'b00010,
    PH_CODE    = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_SUM     = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0] code_ping;
    logic [7:0] code_position_report;
    logic [7:0] code_torque_switch;
    logic [7:0] code_umbrella_open;
    logic [7:0] position_payload_length;
    logic [7:0] buffer_capacity;
  } cfg_t;

  typedef struct packed {
    event_t     event_kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] frame_code;
  } result_t;

endpackage

>>> design/sfp_in_if.sv
// Input byte channel: valid/ready with received byte and restart flag.
`timescale 1ns / 1ps

interface sfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       restart;

  modport source (output valid, output rx_byte, output restart, input ready);
  modport sink (input valid, input rx_byte, input restart, output ready);
endinterface

>>> design/sfp_out_if.sv
// Result channel: valid/ready with event kind, payload byte, index and code.
`timescale 1ns / 1ps

interface sfp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic [7:0] frame_code;

  modport source (output valid, output event_kind, output payload_byte,
                  output payload_index, output frame_code, input ready);
  modport sink (input valid, input event_kind, input payload_byte,
                input payload_index, input frame_code, output ready);
endinterface

>>> design/sfp_regs.sv
// APB-style configuration register file for the frame parser.
`timescale 1ns / 1ps

module sfp_regs
  import sfp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output cfg_t                  cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx   = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en = psel & penable & pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_CODE_PING:     cfg_nxt.code_ping               = pwdata[7:0];
        REG_CODE_POSITION: cfg_nxt.code_position_report    = pwdata[7:0];
        REG_CODE_TORQUE:   cfg_nxt.code_torque_switch      = pwdata[7:0];
        REG_CODE_UMBRELLA: cfg_nxt.code_umbrella_open      = pwdata[7:0];
        REG_PAYLOAD_LEN:   cfg_nxt.position_payload_length = pwdata[7:0];
        REG_BUF_CAPACITY:  cfg_nxt.buffer_capacity         = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.code_ping               <= RST_CODE_PING;
      cfg_r.code_position_report    <= RST_CODE_POSITION;
      cfg_r.code_torque_switch      <= RST_CODE_TORQUE;
      cfg_r.code_umbrella_open      <= RST_CODE_UMBRELLA;
      cfg_r.position_payload_length <= RST_PAYLOAD_LEN;
      cfg_r.buffer_capacity         <= RST_BUF_CAPACITY;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_CODE_PING:     prdata[7:0] = cfg_r.code_ping;
      REG_CODE_POSITION: prdata[7:0] = cfg_r.code_position_report;
      REG_CODE_TORQUE:   prdata[7:0] = cfg_r.code_torque_switch;
      REG_CODE_UMBRELLA: prdata[7:0] = cfg_r.code_umbrella_open;
      REG_PAYLOAD_LEN:   prdata[7:0] = cfg_r.position_payload_length;
      REG_BUF_CAPACITY:  prdata[7:0] = cfg_r.buffer_capacity;
      default:           prdata      = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

>>> design/sfp_parser.sv
// Frame parse state and per-byte next-state / event logic.
`timescale 1ns / 1ps

module sfp_parser
  import sfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  input  logic       restart,
  output result_t    result
);

  phase_t     phase_r, phase_nxt, phase_cur;
  logic [7:0] code_r, code_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] idx_r, idx_nxt;
  logic [7:0] len_r, len_nxt;
  event_t     ev;
  logic [7:0] pbyte;
  logic [7:0] pidx;

  always_comb begin
    phase_cur = restart ? PH_HUNT1 : phase_r;
    phase_nxt = phase_cur;
    code_nxt  = code_r;
    sum_nxt   = sum_r;
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    ev        = EV_NONE;
    pbyte     = '0;
    pidx      = '0;
    case (phase_cur)
      PH_HUNT2: begin
        phase_nxt = (rx_byte == SYNC_BYTE) ? PH_CODE : PH_HUNT1;
      end
      PH_CODE: begin
        code_nxt = rx_byte;
        sum_nxt  = rx_byte;
        idx_nxt  = '0;
        // first match wins: ping, position report, torque, umbrella
        if (rx_byte == cfg.code_ping) begin
          len_nxt   = '0;
          phase_nxt = PH_SUM;
        end else if (rx_byte == cfg.code_position_report) begin
          len_nxt   = cfg.position_payload_length;
          phase_nxt = (cfg.position_payload_length == 8'd0) ? PH_SUM : PH_PAYLOAD;
        end else if (rx_byte == cfg.code_torque_switch ||
                     rx_byte == cfg.code_umbrella_open) begin
          len_nxt   = '0;
          phase_nxt = PH_SUM;
        end else begin
          ev        = EV_UNKNOWN;
          phase_nxt = PH_HUNT1;
        end
      end
      PH_PAYLOAD: begin
        if (idx_r >= cfg.buffer_capacity) begin
          ev        = EV_OVERFLOW;
          phase_nxt = PH_HUNT1;
        end else begin
          ev        = EV_BYTE;
          pbyte     = rx_byte;
          pidx      = idx_r;
          idx_nxt   = idx_r + 8'd1;
          sum_nxt   = sum_r + rx_byte;
          if (idx_nxt >= len_r) begin
            phase_nxt = PH_SUM;
          end
        end
      end
      PH_SUM: begin
        ev        = (rx_byte == sum_r) ? EV_GOOD : EV_BADSUM;
        phase_nxt = PH_HUNT1;
      end
      default: begin
        phase_nxt = (rx_byte == SYNC_BYTE) ? PH_HUNT2 : PH_HUNT1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT1;
      code_r  <= '0;
      sum_r   <= '0;
      idx_r   <= '0;
      len_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      code_r  <= code_nxt;
      sum_r   <= sum_nxt;
      idx_r   <= idx_nxt;
      len_r   <= len_nxt;
    end
  end

  assign result.event_kind    = ev;
  assign result.payload_byte  = pbyte;
  assign result.payload_index = pidx;
  assign result.frame_code    = (ev != EV_NONE) ? code_nxt : 8'd0;

endmodule

>>> design/sync_frame_parser_sum_check.sv
// Top level: two-byte sync frame parser with 8-bit sum check.
// An accepted byte beat's result beat appears in the following cycle.
// Throughput: one byte per cycle unless stalled; one result beat per byte.
// The output register doubles as the skid stage: a new byte is taken while a
// result waits, as long as that result is being taken in the same cycle.
// Reset (rst_n low, synchronous): hunt state, parse state and the output
// valid clear; configuration registers return to their default codes.
`timescale 1ns / 1ps

module sync_frame_parser_sum_check
  import sfp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  sfp_in_if.sink                in_ch,
  sfp_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t    cfg;
  result_t res;
  result_t res_r;
  logic    out_valid_r, out_valid_nxt;
  logic    in_accept;

  // APB never stalls
  assign pready = 1'b1;

  sfp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // Room for a byte whenever the result slot is empty or draining this cycle.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;

  sfp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .accept  (in_accept),
    .rx_byte (in_ch.rx_byte),
    .restart (in_ch.restart),
    .result  (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload register; loads only on an accepted byte beat.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.event_kind    = res_r.event_kind;
  assign out_ch.payload_byte  = res_r.payload_byte;
  assign out_ch.payload_index = res_r.payload_index;
  assign out_ch.frame_code    = res_r.frame_code;

endmodule

>>> dv/sync_frame_parser_sum_check_tb.sv
// Testbench for the sync frame parser: byte stream in, checked event beats out.
`timescale 1ns / 1ps

module sync_frame_parser_sum_check_tb;
  import sfp_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  // One input beat as the driver presents it
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       restart;
  } rx_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  sfp_in_if  in_bus ();
  sfp_out_if out_bus ();

  sync_frame_parser_sum_check u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // Bytes waiting to be driven, and events the parser owes us, oldest first
  rx_beat_t   beat_q[$];
  result_t    event_q[$];
  idle_mode_t idle_mode = IDLE_NONE;
  int         fails = 0;
  int         cycles = 0;

  // Shadow of the register file, kept in step with every write we issue
  cfg_t cfg;

  // Shadow of the parser state
  phase_t     phase;
  logic [7:0] cur_code;
  logic [7:0] run_sum;
  logic [7:0] pay_idx;
  logic [7:0] pay_len;

  // Advance the shadow parser by one byte and return the event it produces.
  function automatic result_t parse_byte(input logic [7:0] b, input logic hunt_now);
    result_t r;
    r = '0;
    r.event_kind = EV_NONE;
    // restart only rewinds the phase; code, sum and index are kept
    if (hunt_now) phase = PH_HUNT1;
    case (phase)
      PH_HUNT2: begin
        // a non-sync byte here is dropped, not retried as a first sync
        phase = (b == SYNC_BYTE) ? PH_CODE : PH_HUNT1;
      end
      PH_CODE: begin
        cur_code = b;
        run_sum  = b;
        pay_idx  = 8'd0;
        // first match wins when codes coincide: ping, position, torque, umbrella
        if (b == cfg.code_ping) begin
          pay_len = 8'd0;
          phase   = PH_SUM;
        end else if (b == cfg.code_position_report) begin
          pay_len = cfg.position_payload_length;
          phase   = (pay_len == 8'd0) ? PH_SUM : PH_PAYLOAD;
        end else if (b == cfg.code_torque_switch || b == cfg.code_umbrella_open) begin
          pay_len = 8'd0;
          phase   = PH_SUM;
        end else begin
          r.event_kind = EV_UNKNOWN;
          phase        = PH_HUNT1;
        end
      end
      PH_PAYLOAD: begin
        if (pay_idx >= cfg.buffer_capacity) begin
          // buffer full: byte is dropped and the frame aborted
          r.event_kind = EV_OVERFLOW;
          phase        = PH_HUNT1;
        end else begin
          r.event_kind    = EV_BYTE;
          r.payload_byte  = b;
          r.payload_index = pay_idx;
          pay_idx         = pay_idx + 8'd1;
          run_sum         = run_sum + b;
          if (pay_idx >= pay_len) phase = PH_SUM;
        end
      end
      PH_SUM: begin
        r.event_kind = (b == run_sum) ? EV_GOOD : EV_BADSUM;
        phase        = PH_HUNT1;
      end
      default: begin
        phase = (b == SYNC_BYTE) ? PH_HUNT2 : PH_HUNT1;
      end
    endcase
    if (r.event_kind != EV_NONE) r.frame_code = cur_code;
    return r;
  endfunction

  function automatic bit sender_idle();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(0, 99) < 78;
      IDLE_BOTH: return $urandom_range(0, 99) < 19;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(0, 99) < 78;
      IDLE_BOTH: return $urandom_range(0, 99) < 19;
      default:   return 1'b0;
    endcase
  endfunction

  // Driver: present the next byte once the current one is gone (or none is up).
  // Each accepted beat is run through the shadow parser right at its edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid   <= 1'b0;
      in_bus.rx_byte <= 8'd0;
      in_bus.restart <= 1'b0;
    end else if (!in_bus.valid || in_bus.ready) begin
      if (in_bus.valid) event_q.push_back(parse_byte(in_bus.rx_byte, in_bus.restart));
      if (beat_q.size() != 0 && !sender_idle()) begin
        in_bus.rx_byte <= beat_q[0].rx_byte;
        in_bus.restart <= beat_q[0].restart;
        in_bus.valid   <= 1'b1;
        void'(beat_q.pop_front());
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Monitor: every event beat must match the oldest outstanding prediction.
  result_t want;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (event_q.size() == 0) begin
          $error("event beat with nothing outstanding: event_kind %0d", out_bus.event_kind);
          fails++;
        end else begin
          want = event_q.pop_front();
          if (out_bus.event_kind !== want.event_kind) begin
            $error("event_kind: expected %0d, got %0d", want.event_kind, out_bus.event_kind);
            fails++;
          end
          if (out_bus.payload_byte !== want.payload_byte) begin
            $error("payload_byte: expected %0d, got %0d", want.payload_byte,
                   out_bus.payload_byte);
            fails++;
          end
          if (out_bus.payload_index !== want.payload_index) begin
            $error("payload_index: expected %0d, got %0d", want.payload_index,
                   out_bus.payload_index);
            fails++;
          end
          if (out_bus.frame_code !== want.frame_code) begin
            $error("frame_code: expected %0d, got %0d", want.frame_code, out_bus.frame_code);
            fails++;
          end
        end
      end
      out_bus.ready <= !receiver_stall();
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("sync_frame_parser_sum_check: mismatch");
      $finish;
    end
  end

  // APB write, then read back the same register. Shadow updated on the write.
  task automatic write_reg(input reg_idx_t idx, input logic [7:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_CODE_PING:     cfg.code_ping               = val;
      REG_CODE_POSITION: cfg.code_position_report    = val;
      REG_CODE_TORQUE:   cfg.code_torque_switch      = val;
      REG_CODE_UMBRELLA: cfg.code_umbrella_open      = val;
      REG_PAYLOAD_LEN:   cfg.position_payload_length = val;
      REG_BUF_CAPACITY:  cfg.buffer_capacity         = val;
      default: ;
    endcase
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== val) begin
      $error("register %0d readback: expected %0d, got %0d", idx, val, prdata[7:0]);
      fails++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Every byte gives exactly one event, so empty queues and no beat on the
  // wire means the parser is quiet; a trailing wait covers the output stage.
  task automatic wait_drained();
    while (beat_q.size() != 0 || in_bus.valid || event_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_beat(input logic [7:0] b, input logic rs);
    beat_q.push_back('{rx_byte: b, restart: rs});
  endtask

  // Queue one stretch of traffic: mostly well-formed frames against the
  // current codes, some with a wrong sum or cut short; the rest is noise.
  task automatic queue_frame(output int n);
    logic [7:0] frame_q[$];
    logic [7:0] code;
    logic [7:0] sum;
    logic [7:0] b;
    int         plen;
    if ($urandom_range(0, 99) < 12) begin
      // noise, biased toward sync bytes to hit half-finished syncs
      repeat ($urandom_range(1, 4))
        frame_q.push_back($urandom_range(0, 1) ? SYNC_BYTE : 8'($urandom));
    end else begin
      if ($urandom_range(0, 4) == 0) frame_q.push_back(8'($urandom));
      frame_q.push_back(SYNC_BYTE);
      frame_q.push_back(SYNC_BYTE);
      case ($urandom_range(0, 9))
        0, 1:       code = cfg.code_ping;
        2, 3, 4, 5: code = cfg.code_position_report;
        6:          code = cfg.code_torque_switch;
        7:          code = cfg.code_umbrella_open;
        default:    code = 8'($urandom);
      endcase
      frame_q.push_back(code);
      sum  = code;
      plen = 0;
      if (code != cfg.code_ping && code == cfg.code_position_report)
        plen = cfg.position_payload_length;
      for (int i = 0; i < plen; i++) begin
        b = 8'($urandom);
        sum += b;
        frame_q.push_back(b);
      end
      frame_q.push_back(($urandom_range(0, 3) != 0) ? sum : 8'($urandom));
      // truncated frame: the next frame's sync lands mid-parse
      if ($urandom_range(0, 99) < 8)
        repeat ($urandom_range(1, frame_q.size() - 1)) void'(frame_q.pop_back());
    end
    foreach (frame_q[i]) push_beat(frame_q[i], $urandom_range(0, 99) < 3);
    n = frame_q.size();
  endtask

  // Reprogram all six registers while idle, then run random traffic.
  task automatic run_phase(input cfg_t c, input idle_mode_t m, input int budget);
    int total;
    int n;
    write_reg(REG_CODE_PING,     c.code_ping);
    write_reg(REG_CODE_POSITION, c.code_position_report);
    write_reg(REG_CODE_TORQUE,   c.code_torque_switch);
    write_reg(REG_CODE_UMBRELLA, c.code_umbrella_open);
    write_reg(REG_PAYLOAD_LEN,   c.position_payload_length);
    write_reg(REG_BUF_CAPACITY,  c.buffer_capacity);
    idle_mode = m;
    total = 0;
    while (total < budget) begin
      queue_frame(n);
      total += n;
    end
    wait_drained();
  endtask

  initial begin
    logic [7:0] x;
    // known levels on every input from time zero
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_bus.valid   = 1'b0;
    in_bus.rx_byte = 8'd0;
    in_bus.restart = 1'b0;
    out_bus.ready  = 1'b0;
    cfg = cfg_t'{RST_CODE_PING, RST_CODE_POSITION, RST_CODE_TORQUE, RST_CODE_UMBRELLA,
                 RST_PAYLOAD_LEN, RST_BUF_CAPACITY};
    phase    = PH_HUNT1;
    cur_code = 8'd0;
    run_sum  = 8'd0;
    pay_idx  = 8'd0;
    pay_len  = 8'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset codes: ping good, torque bad sum, umbrella good
    push_beat(8'hFF, 1'b0); push_beat(8'hFF, 1'b0); push_beat(8'h00, 1'b0);
    push_beat(8'h00, 1'b0);
    push_beat(8'hFF, 1'b0); push_beat(8'hFF, 1'b0); push_beat(8'h02, 1'b0);
    push_beat(8'h03, 1'b0);
    push_beat(8'hFF, 1'b0); push_beat(8'hFF, 1'b0); push_beat(8'h03, 1'b0);
    push_beat(8'h03, 1'b0);
    // broken sync (dropped byte), then an unknown code
    push_beat(8'hFF, 1'b0); push_beat(8'h7F, 1'b0); push_beat(8'hFF, 1'b0);
    push_beat(8'hFF, 1'b0); push_beat(8'h80, 1'b0);
    // payload frame interrupted by restart on a sync byte, then torque good
    push_beat(8'hFF, 1'b0); push_beat(8'hFF, 1'b0); push_beat(8'h01, 1'b0);
    push_beat(8'hA5, 1'b0);
    push_beat(8'hFF, 1'b1); push_beat(8'hFF, 1'b0); push_beat(8'h02, 1'b0);
    push_beat(8'h02, 1'b0);
    wait_drained();

    // Random phases; each one rewrites every register
    run_phase(cfg_t'{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'd4, 8'd4},
              IDLE_NONE, 60);
    // payload longer than the buffer: overflow on every position frame
    run_phase(cfg_t'{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'd7, 8'd3},
              IDLE_SEND, 60);
    // extreme codes, zero-length payload
    run_phase(cfg_t'{8'h00, 8'hFF, 8'h7F, 8'h80, 8'd0, 8'd0}, IDLE_RECV, 50);
    // all four codes equal: ping wins
    x = 8'($urandom);
    run_phase(cfg_t'{x, x, x, x, 8'd2, 8'd255}, IDLE_BOTH, 50);
    // ping and position coincide
    x = 8'($urandom);
    run_phase(cfg_t'{x, x, 8'($urandom), 8'($urandom), 8'd5, 8'd5}, IDLE_NONE, 50);
    // longest payload, index runs to the top
    run_phase(cfg_t'{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     8'd255, 8'd255}, IDLE_SEND, 100);
    // payload into an empty buffer
    run_phase(cfg_t'{8'hFF, 8'h00, 8'($urandom), 8'($urandom), 8'd20, 8'd0},
              IDLE_RECV, 50);
    run_phase(cfg_t'{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom_range(0, 10)), 8'($urandom_range(0, 10))}, IDLE_BOTH, 60);
    run_phase(cfg_t'{RST_CODE_PING, RST_CODE_POSITION, RST_CODE_TORQUE, RST_CODE_UMBRELLA,
                     RST_PAYLOAD_LEN, RST_BUF_CAPACITY}, IDLE_NONE, 50);

    repeat (10) @(posedge clk);
    if (fails == 0 && event_q.size() == 0) begin
      $display("sync_frame_parser_sum_check: match");
    end else begin
      $display("sync_frame_parser_sum_check: mismatch");
    end
    $finish;
  end

endmodule
